// ----- hw/rtl/ptbl_pkg.sv -----
// shared types and constants for the paper tape binary loader
// no dependencies; used by ptbl_decode and paper_tape_binary_loader
package ptbl_pkg;

    localparam logic [7:0] RUBOUT_CODE = 8'o377;
    localparam logic [7:0] MARK_CODE   = 8'o200;

    localparam int FRAME_W = 8;
    localparam int WORD_W  = 12;
    localparam int FIELD_W = 3;
    localparam int ADDR_W  = FIELD_W + WORD_W;
    localparam int KIND_W  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE    = 2'd0,
        KIND_SUM_GOOD = 2'd1,
        KIND_SUM_BAD  = 2'd2
    } kind_t;

    // leader, expecting low frame, expecting high frame or trailer, load ended
    typedef enum logic [3:0] {
        PH_LEADER = 4'b0001,
        PH_LOW    = 4'b0010,
        PH_HIGH   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } result_t;

endpackage

// ----- hw/rtl/paper_tape_binary_loader.sv -----
// Paper tape loader for the binary absolute-loader format. Takes one raw tape frame per
// transfer and gives a memory write (field:origin, 12-bit word) for each data word, and one
// final checksum result when the trailer frame ends the load; frames after that are dropped.
// A frame is taken every cycle while the result side is not stalled. A frame passes an input
// register, then one decode step against the loader state, then the result register, which
// presents the result. Reset clears all loader state.
// depends on ptbl_pkg and ptbl_decode
module paper_tape_binary_loader
    import ptbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FRAME_W-1:0]   tape_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    result_kind,
    output logic [ADDR_W-1:0]    write_address,
    output logic [WORD_W-1:0]    write_data
);

    logic                in_valid_reg;
    logic [FRAME_W-1:0]  in_byte_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic                advance;
    logic                in_load;
    logic                step;
    logic                res_valid;
    result_t             res;

    // the frame register moves on whenever the result register is free or being emptied
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_load  = in_valid && !in_stall;
    assign step     = in_valid_reg && advance;

    ptbl_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .frame     (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= tape_byte;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign write_address = out_reg.addr;
    assign write_data    = out_reg.data;

endmodule

// ----- hw/rtl/ptbl_decode.sv -----
// loader state and per-frame decode: rubout, field, leader, word and trailer handling
// depends on ptbl_pkg
module ptbl_decode
    import ptbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [FRAME_W-1:0]   frame,
    output logic                 res_valid,
    output result_t              res
);

    phase_t              phase_reg,   phase_next;
    logic                skip_reg,    skip_next;
    logic [FIELD_W-1:0]  pending_reg, pending_next;
    logic [FIELD_W-1:0]  active_reg,  active_next;
    logic [FRAME_W-1:0]  high_reg,    high_next;
    logic [FRAME_W-1:0]  low_reg,     low_next;
    logic [WORD_W-1:0]   sum_reg,     sum_next;
    logic [WORD_W-1:0]   origin_reg,  origin_next;

    logic [WORD_W+1:0]   word;
    logic [WORD_W-1:0]   check;

    // the frames overlap by two bits, as in the tape format
    assign word  = {high_reg, 6'b0} | {6'b0, low_reg};
    assign check = sum_reg - word[WORD_W-1:0];

    always_comb
    begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        sum_next     = sum_reg;
        origin_next  = origin_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (step && phase_reg != PH_DONE)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (frame == RUBOUT_CODE)
            begin
                skip_next = 1'b1;
            end
            else if (frame > MARK_CODE)
            begin
                pending_next = frame[5:3];
            end
            else
            begin
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        low_next   = frame;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        if (frame == MARK_CODE)
                        begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res.kind   = (check != '0) ? KIND_SUM_BAD : KIND_SUM_GOOD;
                        end
                        else
                        begin
                            sum_next = sum_reg + {4'b0, low_reg} + {4'b0, high_reg};
                            if (word[WORD_W+1:WORD_W] != 2'b0)
                            begin
                                origin_next = word[WORD_W-1:0];
                            end
                            else
                            begin
                                res_valid   = 1'b1;
                                res.kind    = KIND_WRITE;
                                res.addr    = {active_reg, origin_reg};
                                res.data    = word[WORD_W-1:0];
                                origin_next = origin_reg + WORD_W'(1);
                            end
                            active_next = pending_reg;
                            high_next   = frame;
                            phase_next  = PH_LOW;
                        end
                    end
                    PH_LEADER:
                    begin
                        if (frame != '0 && frame != MARK_CODE)
                        begin
                            phase_next = PH_LOW;
                        end
                        high_next = frame;
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_LEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEADER;
            skip_reg    <= 1'b0;
            pending_reg <= '0;
            active_reg  <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
            sum_reg     <= '0;
            origin_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
            sum_reg     <= sum_next;
            origin_reg  <= origin_next;
        end
    end

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("loader left the ended state");

    a_end_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != KIND_WRITE |=> phase_reg == PH_DONE)
        else $error("end result without ending the load");

    a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> !res_valid)
        else $error("result produced after the load ended");

    a_skip_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        step && skip_reg && phase_reg != PH_DONE |-> !res_valid)
        else $error("frame after a rubout produced a result");
`endif

endmodule

// ----- sim/paper_tape_binary_loader_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for paper_tape_binary_loader: directed tape frames, then random ones
// depends on ptbl_pkg and the loader rtl; the load is closed by a checksum trailer at the end
module paper_tape_binary_loader_tb;
    import ptbl_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               typed;
        logic               hit;
        result_t            res;
    } tape_row_t;

    localparam result_t NO_RES = '0;
    localparam int RANDOM_FRAMES = 1900;
    localparam int SCRIPT_LEN = 24;

    // typed rows carry their own expectation, the rest go through the decoder model
    localparam tape_row_t SCRIPT [SCRIPT_LEN] = '{
        '{8'o000, 1'b1, 1'b0, NO_RES},  // leader
        '{8'o200, 1'b1, 1'b0, NO_RES},  // leader mark
        '{8'o377, 1'b1, 1'b0, NO_RES},  // rubout
        '{8'o101, 1'b1, 1'b0, NO_RES},  // dropped after rubout
        '{8'o370, 1'b1, 1'b0, NO_RES},  // field 7 pending
        '{8'o100, 1'b1, 1'b0, NO_RES},  // first high frame
        '{8'o000, 1'b1, 1'b0, NO_RES},
        '{8'o001, 1'b1, 1'b0, NO_RES},  // origin word 0
        '{8'o002, 1'b1, 1'b0, NO_RES},
        '{8'o077, 1'b0, 1'b0, NO_RES},  // write in field 7
        '{8'o200, 1'b1, 1'b0, NO_RES},  // low frame of 0200
        '{8'o201, 1'b1, 1'b0, NO_RES},  // back to field 0
        '{8'o377, 1'b1, 1'b0, NO_RES},
        '{8'o200, 1'b1, 1'b0, NO_RES},  // trailer hidden by rubout
        '{8'o000, 1'b0, 1'b0, NO_RES},
        '{8'o377, 1'b1, 1'b0, NO_RES},
        '{8'o377, 1'b1, 1'b0, NO_RES},  // rubout dropped by rubout
        '{8'o177, 1'b1, 1'b0, NO_RES},
        '{8'o177, 1'b0, 1'b0, NO_RES},
        '{8'o077, 1'b1, 1'b0, NO_RES},
        '{8'o050, 1'b0, 1'b0, NO_RES},  // origin 07777
        '{8'o070, 1'b1, 1'b0, NO_RES},
        '{8'o001, 1'b0, 1'b0, NO_RES},  // write at 07777, origin wraps
        '{8'o000, 1'b1, 1'b0, NO_RES}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FRAME_W-1:0]   tape_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    result_kind;
    logic [ADDR_W-1:0]    write_address;
    logic [WORD_W-1:0]    write_data;

    // decoder model state
    logic               skip_q;
    phase_t             phase_q;
    logic [FIELD_W-1:0] pend_field_q;
    logic [FIELD_W-1:0] act_field_q;
    logic [7:0]         high_q;
    logic [7:0]         low_q;
    logic [WORD_W-1:0]  sum_q;
    logic [WORD_W-1:0]  origin_q;

    result_t pending_results[$];
    bit      calm = 1'b0;
    int      errors = 0;
    int      frames_sent = 0;
    int      writes_seen = 0;
    int      ends_seen = 0;
    logic    end_good = 1'b0;

    paper_tape_binary_loader u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .tape_byte     (tape_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .write_address (write_address),
        .write_data    (write_data)
    );

    always #5 clk = ~clk;

    task automatic advance_loader(input logic [7:0] b, output logic hit, output result_t r);
        logic [13:0] word;
        hit = 1'b0;
        r = '0;
        word = {high_q, 6'd0} | {6'd0, low_q};
        if (phase_q == PH_DONE)
            return;
        if (skip_q)
        begin
            skip_q = 1'b0;
            return;
        end
        if (b == RUBOUT_CODE)
        begin
            skip_q = 1'b1;
            return;
        end
        if (b > MARK_CODE)
        begin
            pend_field_q = b[5:3];
            return;
        end
        case (phase_q)
            PH_LOW:
            begin
                low_q = b;
                phase_q = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (b == MARK_CODE)
                begin
                    phase_q = PH_DONE;
                    hit = 1'b1;
                    if (sum_q == word[11:0])
                        r.kind = KIND_SUM_GOOD;
                    else
                        r.kind = KIND_SUM_BAD;
                    return;
                end
                sum_q = sum_q + {4'd0, low_q} + {4'd0, high_q};
                if (word[13:12] != 2'b00)
                    origin_q = word[11:0];
                else
                begin
                    hit = 1'b1;
                    r.kind = KIND_WRITE;
                    r.addr = {act_field_q, origin_q};
                    r.data = word[11:0];
                    origin_q = origin_q + 12'd1;
                end
                act_field_q = pend_field_q;
                high_q = b;
                phase_q = PH_LOW;
            end
            default:
            begin
                if (b != 8'o000 && b != MARK_CODE)
                    phase_q = PH_LOW;
                else
                    phase_q = PH_LEADER;
                high_q = b;
            end
        endcase
    endtask

    // one frame transfer; the model runs at the transfer so the next frame sees fresh state
    task automatic send_frame(input logic [7:0] b, input logic typed, input logic t_hit,
                              input result_t t_res);
        logic    hit;
        result_t r;
        while (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tape_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        advance_loader(b, hit, r);
        if (typed)
        begin
            hit = t_hit;
            r = t_res;
        end
        if (hit)
            pending_results.push_back(r);
        frames_sent++;
    endtask

    always @(posedge clk)
        out_stall <= rst_n && !calm && ($urandom_range(99) < 15);

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {result_kind, write_address, write_data};
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind %0d addr %o data %o",
                             got.kind, got.addr, got.data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind != want.kind || got.addr != want.addr || got.data != want.data)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want kind %0d addr %o data %o, got %0d %o %o",
                                 want.kind, want.addr, want.data,
                                 got.kind, got.addr, got.data);
                end
                if (got.kind == KIND_WRITE)
                    writes_seen++;
                else
                    ends_seen++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]        b;
        int                roll;
        logic [WORD_W-1:0] close_sum;
        logic              bad_sum;
        skip_q = 1'b0;
        phase_q = PH_LEADER;
        pend_field_q = '0;
        act_field_q = '0;
        high_q = '0;
        low_q = '0;
        sum_q = '0;
        origin_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_frame(SCRIPT[i].frame, SCRIPT[i].typed, SCRIPT[i].hit, SCRIPT[i].res);

        for (int i = 0; i < RANDOM_FRAMES; i++)
        begin
            calm = (i >= 700 && i < 1000);
            roll = $urandom_range(99);
            if (roll < 70)
                b = 8'($urandom_range(8'o177));
            else if (roll < 78)
                b = 8'($urandom_range(8'o376, 8'o201));
            else if (roll < 83)
                b = RUBOUT_CODE;
            else if (roll < 88)
                b = MARK_CODE;
            else
                b = 8'($urandom_range(255));
            // a trailer here would end the load early
            if (b == MARK_CODE && !skip_q && phase_q == PH_HIGH)
                b = 8'($urandom_range(8'o177));
            send_frame(b, 1'b0, 1'b0, NO_RES);
        end

        // bring the parser to where a high frame is due, then send the checksum word
        while (skip_q || phase_q != PH_HIGH)
        begin
            if (skip_q)
                b = 8'($urandom_range(255));
            else if (phase_q == PH_LEADER)
                b = 8'o001;
            else
                b = 8'o000;
            send_frame(b, 1'b0, 1'b0, NO_RES);
        end
        close_sum = sum_q + {4'd0, high_q} + {4'd0, low_q};
        bad_sum = 1'($urandom_range(1));
        end_good = !bad_sum;
        send_frame({2'b00, close_sum[11:6]}, 1'b0, 1'b0, NO_RES);
        send_frame({2'b00, close_sum[5:0] ^ {5'd0, bad_sum}}, 1'b0, 1'b0, NO_RES);
        send_frame(MARK_CODE, 1'b1, 1'b1,
                   bad_sum ? result_t'{KIND_SUM_BAD, '0, '0} : result_t'{KIND_SUM_GOOD, '0, '0});
        // everything after the trailer must be dropped
        for (int i = 0; i < 12; i++)
            send_frame(8'($urandom_range(255)), 1'b0, 1'b0, NO_RES);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d tape frames, checked %0d memory writes and %0d load end result(s)",
                 frames_sent, writes_seen, ends_seen);
        $display("load closed with checksum %s", end_good ? "good" : "bad");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ptbl_pkg.sv
hw/rtl/ptbl_decode.sv
hw/rtl/paper_tape_binary_loader.sv
sim/paper_tape_binary_loader_tb.sv
